@@ sv/lrga_pkg.sv @@
package lrga_pkg;

  localparam int MAX_NODES = 256;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int NCNT_W    = NODE_AW + 1;
  localparam int MAX_LINKS = 1024;
  localparam int LINK_AW   = $clog2(MAX_LINKS);
  localparam int LTOT_W    = LINK_AW + 1;
  localparam int GEN_W     = 16;
  localparam int CNT_W     = 3;

  localparam logic [CNT_W-1:0] CNT_SAT   = 3'd4;
  localparam logic [CNT_W-1:0] CNT_BIRTH = 3'd3;
  localparam logic [CNT_W-1:0] CNT_SURV  = 3'd2;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_LINK = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One node entry: current state, state one generation back, neighbor count.
  typedef struct packed {
    logic             alive;
    logic             prev;
    logic [CNT_W-1:0] count;
  } node_word_t;

  typedef struct packed {
    logic [NODE_AW-1:0] src;
    logic [NODE_AW-1:0] tgt;
  } link_entry_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_word_t         wdata;
    logic [NODE_AW-1:0] ra_addr;
    logic [NODE_AW-1:0] rb_addr;
  } node_port_t;

  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] waddr;
    link_entry_t        wdata;
    logic [LINK_AW-1:0] raddr;
  } link_port_t;

  typedef struct packed {
    logic               start;
    logic [1:0]         req_type;
    logic [NODE_AW-1:0] node_id;
    logic [NODE_AW-1:0] target_index;
    logic               alive_value;
    logic [GEN_W-1:0]   generation_count;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic              read_alive;
    logic [1:0]        status;
    logic [LTOT_W-1:0] links_used;
  } resp_t;

  // B3/S23 rule on a saturated neighbor count.
  function automatic logic next_alive(input logic alive, input logic [CNT_W-1:0] count);
    if (alive) begin
      return (count == CNT_SURV) || (count == CNT_BIRTH);
    end
    return count == CNT_BIRTH;
  endfunction

endpackage

@@ sv/lrga_node_table.sv @@
module lrga_node_table (
  input  logic                  clk,
  input  lrga_pkg::node_port_t  port,
  output lrga_pkg::node_word_t  rd_a,
  output lrga_pkg::node_word_t  rd_b
);

  lrga_pkg::node_word_t mem [lrga_pkg::MAX_NODES];

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rd_a <= mem[port.ra_addr];
    rd_b <= mem[port.rb_addr];
  end

endmodule

@@ sv/lrga_link_table.sv @@
module lrga_link_table (
  input  logic                  clk,
  input  lrga_pkg::link_port_t  port,
  output lrga_pkg::link_entry_t rd
);

  lrga_pkg::link_entry_t mem [lrga_pkg::MAX_LINKS];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rd <= mem[port.raddr];
  end

endmodule

@@ sv/lrga_engine.sv @@
module lrga_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lrga_pkg::NCNT_W-1:0]     node_count,
  input  lrga_pkg::cmd_t                  cmd,
  input  logic                            deliver_ok,
  output logic                            idle,
  output lrga_pkg::resp_t                 resp,
  output lrga_pkg::node_port_t            node_port,
  input  lrga_pkg::node_word_t            node_rd_a,
  input  lrga_pkg::node_word_t            node_rd_b,
  output lrga_pkg::link_port_t            link_port,
  input  lrga_pkg::link_entry_t           link_rd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_EDGE  = 4'd3;
  localparam logic [3:0] S_NODE  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_RESP  = 4'd7;
  localparam logic [3:0] S_INIT  = 4'd8;

  logic [3:0]                     state;
  logic [1:0]                     req_q;
  logic [lrga_pkg::NODE_AW-1:0]   ni_q;
  logic [lrga_pkg::NODE_AW-1:0]   ti_q;
  logic                           av_q;
  logic [lrga_pkg::GEN_W-1:0]     gens_q;
  logic [lrga_pkg::GEN_W-1:0]     gens_left;
  logic [1:0]                     status_q;
  logic [lrga_pkg::LTOT_W-1:0]    link_total;
  logic                           have_prev;
  logic                           changed;
  logic                           diff_prev;
  logic [lrga_pkg::NCNT_W-1:0]    idx;
  logic                           p_v;
  logic [lrga_pkg::NODE_AW-1:0]   p_addr;
  logic [lrga_pkg::LTOT_W-1:0]    eidx;
  logic                           e1_v;
  logic                           e2_v;
  logic [lrga_pkg::NODE_AW-1:0]   e2_s;
  logic                           e2_rng;
  logic                           fwd_v;
  logic [lrga_pkg::NODE_AW-1:0]   fwd_addr;
  lrga_pkg::node_word_t           fwd_word;

  logic                           ni_ok;
  logic                           ti_ok;
  logic                           link_full;
  logic                           e1_rng;
  lrga_pkg::node_word_t           e2_word;
  logic                           e2_inc;
  logic                           new_alive;
  logic [lrga_pkg::GEN_W-1:0]     left;

  assign ni_ok     = {1'b0, ni_q} < node_count;
  assign ti_ok     = {1'b0, ti_q} < node_count;
  assign link_full = link_total == lrga_pkg::LTOT_W'(lrga_pkg::MAX_LINKS);
  assign e1_rng    = ({1'b0, link_rd.src} < node_count) && ({1'b0, link_rd.tgt} < node_count);

  // The count read for a link misses the write made by the link just ahead
  // of it; that write is registered and forwarded here.
  assign e2_word   = (fwd_v && (fwd_addr == e2_s)) ? fwd_word : node_rd_b;
  assign e2_inc    = e2_v && e2_rng && node_rd_a.alive && (e2_word.count < lrga_pkg::CNT_SAT);
  assign new_alive = lrga_pkg::next_alive(node_rd_b.alive, node_rd_b.count);
  assign left      = gens_left - lrga_pkg::GEN_W'(1);

  always_comb begin
    node_port.we      = 1'b0;
    node_port.waddr   = p_addr;
    node_port.wdata   = '0;
    node_port.ra_addr = link_rd.tgt;
    node_port.rb_addr = ni_q;
    unique case (state)
      S_INIT: begin
        node_port.we    = 1'b1;
        node_port.waddr = idx[lrga_pkg::NODE_AW-1:0];
      end
      S_EXEC: begin
        if (req_q == lrga_pkg::REQ_SET && ni_ok) begin
          node_port.we          = 1'b1;
          node_port.waddr       = ni_q;
          node_port.wdata.alive = av_q;
        end
      end
      S_CLR: begin
        node_port.rb_addr = idx[lrga_pkg::NODE_AW-1:0];
        if (p_v) begin
          node_port.we          = 1'b1;
          node_port.wdata.alive = node_rd_b.alive;
          node_port.wdata.prev  = node_rd_b.prev;
        end
      end
      S_EDGE: begin
        node_port.rb_addr = link_rd.src;
        if (e2_inc) begin
          node_port.we          = 1'b1;
          node_port.waddr       = e2_s;
          node_port.wdata.alive = e2_word.alive;
          node_port.wdata.prev  = e2_word.prev;
          node_port.wdata.count = e2_word.count + lrga_pkg::CNT_W'(1);
        end
      end
      S_NODE: begin
        node_port.rb_addr = idx[lrga_pkg::NODE_AW-1:0];
        if (p_v) begin
          node_port.we          = 1'b1;
          node_port.wdata.alive = new_alive;
          node_port.wdata.prev  = node_rd_b.alive;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    link_port.we        = (state == S_EXEC) && (req_q == lrga_pkg::REQ_LINK) &&
                          ni_ok && ti_ok && !link_full;
    link_port.waddr     = link_total[lrga_pkg::LINK_AW-1:0];
    link_port.wdata.src = ni_q;
    link_port.wdata.tgt = ti_q;
    link_port.raddr     = eidx[lrga_pkg::LINK_AW-1:0];
  end

  assign idle            = state == S_IDLE;
  assign resp.valid      = (state == S_RESP) && deliver_ok;
  assign resp.read_alive = ni_ok & node_rd_b.alive;
  assign resp.status     = status_q;
  assign resp.links_used = link_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      idx        <= '0;
      link_total <= '0;
      p_v        <= 1'b0;
      e1_v       <= 1'b0;
      e2_v       <= 1'b0;
      fwd_v      <= 1'b0;
    end else begin
      fwd_v <= 1'b0;
      unique case (state)
        S_INIT: begin
          // Every node entry is zeroed once after reset, one per cycle.
          idx <= idx + lrga_pkg::NCNT_W'(1);
          if (idx == lrga_pkg::NCNT_W'(lrga_pkg::MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.start) begin
            req_q  <= cmd.req_type;
            ni_q   <= cmd.node_id;
            ti_q   <= cmd.target_index;
            av_q   <= cmd.alive_value;
            gens_q <= cmd.generation_count;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_q <= lrga_pkg::ST_OK;
          state    <= S_RD;
          unique case (req_q)
            lrga_pkg::REQ_LINK: begin
              if (!ni_ok || !ti_ok) begin
                status_q <= lrga_pkg::ST_RANGE;
              end else if (link_full) begin
                status_q <= lrga_pkg::ST_FULL;
              end else begin
                link_total <= link_total + lrga_pkg::LTOT_W'(1);
              end
            end
            lrga_pkg::REQ_RUN: begin
              if (gens_q != '0) begin
                gens_left <= gens_q;
                have_prev <= 1'b0;
                idx       <= '0;
                p_v       <= 1'b0;
                state     <= S_CLR;
              end
            end
            default: begin
              if (!ni_ok) begin
                status_q <= lrga_pkg::ST_RANGE;
              end
            end
          endcase
        end
        S_CLR: begin
          p_v <= 1'b0;
          if (idx < node_count) begin
            p_v    <= 1'b1;
            p_addr <= idx[lrga_pkg::NODE_AW-1:0];
            idx    <= idx + lrga_pkg::NCNT_W'(1);
          end else if (!p_v) begin
            eidx  <= '0;
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          e1_v <= 1'b0;
          if (eidx < link_total) begin
            e1_v <= 1'b1;
            eidx <= eidx + lrga_pkg::LTOT_W'(1);
          end
          e2_v   <= e1_v;
          e2_s   <= link_rd.src;
          e2_rng <= e1_rng;
          if (e2_inc) begin
            fwd_v    <= 1'b1;
            fwd_addr <= e2_s;
            fwd_word <= node_port.wdata;
          end
          if (eidx == link_total && !e1_v && !e2_v) begin
            idx       <= '0;
            p_v       <= 1'b0;
            changed   <= 1'b0;
            diff_prev <= 1'b0;
            state     <= S_NODE;
          end
        end
        S_NODE: begin
          p_v <= 1'b0;
          if (idx < node_count) begin
            p_v    <= 1'b1;
            p_addr <= idx[lrga_pkg::NODE_AW-1:0];
            idx    <= idx + lrga_pkg::NCNT_W'(1);
          end else if (!p_v) begin
            state <= S_CHECK;
          end
          if (p_v) begin
            changed   <= changed | (new_alive != node_rd_b.alive);
            diff_prev <= diff_prev | (new_alive != node_rd_b.prev);
          end
        end
        S_CHECK: begin
          // A fixed point ends the run. A period-two oscillation needs at most one
          // more generation to land on the phase the full run ends on.
          if (left == '0 || !changed) begin
            state <= S_RD;
          end else if (have_prev && !diff_prev) begin
            if (left[0]) begin
              gens_left <= lrga_pkg::GEN_W'(1);
              eidx      <= '0;
              state     <= S_EDGE;
            end else begin
              state <= S_RD;
            end
          end else begin
            gens_left <= left;
            have_prev <= 1'b1;
            eidx      <= '0;
            state     <= S_EDGE;
          end
        end
        S_RD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (deliver_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/life_rule_graph_automaton_core.sv @@
// Channel    Handshake                  Payload
// input      in_valid / in_ready        req_type, node_id, target_index,
//                                       alive_value, generation_count
// output     out_valid / out_ready      read_alive, status, links_used
// config     cfg_write_en               cfg_write_data (node_count)
//
// Set, link and read requests each pass through the execute, read and response
// states; a run of G generations takes one pass that clears the counts, then at
// most one link pass and one node pass per generation.
// Reset empties the link table, sets node_count to 256 and zeroes the node memory
// with in_ready low. A result waiting in the output register holds back the next
// request's result, but not the next transfer in.
module life_rule_graph_automaton_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        req_type,
  input  logic [lrga_pkg::NODE_AW-1:0]      node_id,
  input  logic [lrga_pkg::NODE_AW-1:0]      target_index,
  input  logic                              alive_value,
  input  logic [lrga_pkg::GEN_W-1:0]        generation_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              read_alive,
  output logic [1:0]                        status,
  output logic [lrga_pkg::LTOT_W-1:0]       links_used,
  input  logic                              cfg_write_en,
  input  logic [lrga_pkg::NCNT_W-1:0]       cfg_write_data
);

  logic [lrga_pkg::NCNT_W-1:0] node_count;
  logic [lrga_pkg::NCNT_W-1:0] cfg_clamped;
  logic                        eng_idle;
  logic                        deliver_ok;
  lrga_pkg::cmd_t              cmd;
  lrga_pkg::resp_t             resp;
  lrga_pkg::node_port_t        node_port;
  lrga_pkg::node_word_t        node_rd_a;
  lrga_pkg::node_word_t        node_rd_b;
  lrga_pkg::link_port_t        link_port;
  lrga_pkg::link_entry_t       link_rd;

  always_comb begin
    cfg_clamped = cfg_write_data;
    if (cfg_write_data == '0) begin
      cfg_clamped = lrga_pkg::NCNT_W'(1);
    end else if (cfg_write_data > lrga_pkg::NCNT_W'(lrga_pkg::MAX_NODES)) begin
      cfg_clamped = lrga_pkg::NCNT_W'(lrga_pkg::MAX_NODES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= lrga_pkg::NCNT_W'(lrga_pkg::MAX_NODES);
    end else if (cfg_write_en) begin
      node_count <= cfg_clamped;
    end
  end

  assign in_ready   = eng_idle;
  assign deliver_ok = !out_valid || out_ready;

  always_comb begin
    cmd.start            = in_valid && in_ready;
    cmd.req_type         = req_type;
    cmd.node_id          = node_id;
    cmd.target_index     = target_index;
    cmd.alive_value      = alive_value;
    cmd.generation_count = generation_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.valid) begin
      read_alive <= resp.read_alive;
      status     <= resp.status;
      links_used <= resp.links_used;
    end
  end

  lrga_node_table u_node_table (
    .clk  (clk),
    .port (node_port),
    .rd_a (node_rd_a),
    .rd_b (node_rd_b)
  );

  lrga_link_table u_link_table (
    .clk  (clk),
    .port (link_port),
    .rd   (link_rd)
  );

  lrga_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .node_count (node_count),
    .cmd        (cmd),
    .deliver_ok (deliver_ok),
    .idle       (eng_idle),
    .resp       (resp),
    .node_port  (node_port),
    .node_rd_a  (node_rd_a),
    .node_rd_b  (node_rd_b),
    .link_port  (link_port),
    .link_rd    (link_rd)
  );

endmodule

@@ sv/lrga_checker.sv @@
module lrga_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           read_alive,
  input logic [1:0]                     status,
  input logic [lrga_pkg::LTOT_W-1:0]    links_used
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({read_alive, status, links_used}))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == lrga_pkg::ST_OK || status == lrga_pkg::ST_RANGE ||
                   status == lrga_pkg::ST_FULL))
    else $error("undefined status code");

  // A full link table is reported only when every slot is in use.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == lrga_pkg::ST_FULL |->
      links_used == lrga_pkg::LTOT_W'(lrga_pkg::MAX_LINKS))
    else $error("table full with free slots");

  a_links_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> links_used <= lrga_pkg::LTOT_W'(lrga_pkg::MAX_LINKS))
    else $error("link count beyond capacity");

endmodule

bind life_rule_graph_automaton_core lrga_checker u_lrga_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_alive (read_alive),
  .status     (status),
  .links_used (links_used)
);
